>>> hdl/wrtcf_pkg.sv
package wrtcf_pkg;

    localparam int LfsrW     = 16;
    localparam int ModW      = 9;
    localparam int FrameLen  = 10;
    localparam int IdxW      = $clog2(FrameLen);
    localparam int CfgAddrW  = 5;
    localparam int CfgDataW  = 32;

    localparam logic [LfsrW-1:0] LfsrReset = 16'hACE1;
    localparam logic [LfsrW-1:0] LfsrTaps  = 16'hB400;

    localparam logic [7:0] FrameStart = 8'h7E;
    localparam logic [7:0] FrameVer   = 8'hFF;
    localparam logic [7:0] FrameLenB  = 8'h06;
    localparam logic [7:0] FrameAck   = 8'h00;
    localparam logic [7:0] FrameEnd   = 8'hEF;
    localparam logic [7:0] PlayCmd    = 8'h0F;
    localparam logic [ModW-1:0] PickMod = 9'd100;

    // register indexes (byte address / 4)
    localparam logic [2:0] RegFolderA  = 3'd0;
    localparam logic [2:0] RegFirstA   = 3'd1;
    localparam logic [2:0] RegLastA    = 3'd2;
    localparam logic [2:0] RegFolderB  = 3'd3;
    localparam logic [2:0] RegFirstB   = 3'd4;
    localparam logic [2:0] RegLastB    = 3'd5;
    localparam logic [2:0] RegWeightA  = 3'd6;

    typedef struct packed {
        logic       kind;
        logic [7:0] command;
        logic [7:0] param_high;
        logic [7:0] param_low;
        logic [7:0] entropy;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out_item;

    function automatic logic [LfsrW-1:0] lfsr_step(input logic [LfsrW-1:0] v);
        logic [LfsrW-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LfsrTaps;
        end
        return s;
    endfunction

endpackage

>>> hdl/wrtcf_mod.sv
module wrtcf_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wrtcf_pkg::LfsrW-1:0]   i_dividend,
    input  logic [wrtcf_pkg::ModW-1:0]    i_divisor,
    output logic                          o_done,
    output logic [wrtcf_pkg::ModW-1:0]    o_rem
);

    localparam int CntW = $clog2(wrtcf_pkg::LfsrW);

    logic                          r_busy;
    logic                          r_done;
    logic [CntW-1:0]               r_cnt;
    logic [wrtcf_pkg::LfsrW-1:0]   r_dvd;
    logic [wrtcf_pkg::ModW-1:0]    r_div;
    logic [wrtcf_pkg::ModW-1:0]    r_rem;
    logic [wrtcf_pkg::ModW:0]      w_shift;
    logic [wrtcf_pkg::ModW:0]      w_diff;
    logic [wrtcf_pkg::ModW-1:0]    n_rem;

    // restoring remainder, one dividend bit per cycle, MSB first
    always_comb begin
        w_shift = {r_rem, r_dvd[wrtcf_pkg::LfsrW-1]};
        w_diff  = w_shift - {1'b0, r_div};
        if (w_shift >= {1'b0, r_div}) begin
            n_rem = w_diff[wrtcf_pkg::ModW-1:0];
        end else begin
            n_rem = w_shift[wrtcf_pkg::ModW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(wrtcf_pkg::LfsrW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> hdl/weighted_random_track_command_framer.sv
// A direct command goes through states S_SUM and S_SEND before its first frame byte
// is registered; a random play first runs two bit-serial remainder passes.
// A new item is taken only in S_IDLE, once the last byte of a frame is loaded, so
// items do not overlap; ten bytes go out through a single output register.
// Reset (synchronous, active low) loads the register defaults, seeds the LFSR with
// 0xACE1, clears the seed flag and empties the output register.
module weighted_random_track_command_framer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  wrtcf_pkg::t_in_item              i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output wrtcf_pkg::t_out_item             o_out_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wrtcf_pkg::CfgAddrW-1:0]   paddr,
    input  logic [wrtcf_pkg::CfgDataW-1:0]   pwdata,
    output logic [wrtcf_pkg::CfgDataW-1:0]   prdata,
    output logic                             pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK_GO,
        S_PICK_WAIT,
        S_FILE_GO,
        S_FILE_WAIT,
        S_SUM,
        S_SEND
    } t_state;

    t_state                              r_state;
    logic [7:0]                          r_folder_a;
    logic [7:0]                          r_first_a;
    logic [7:0]                          r_last_a;
    logic [7:0]                          r_folder_b;
    logic [7:0]                          r_first_b;
    logic [7:0]                          r_last_b;
    logic [6:0]                          r_weight_a;
    logic [wrtcf_pkg::LfsrW-1:0]         r_lfsr;
    logic                                r_seed_done;
    logic [7:0]                          r_cmd;
    logic [7:0]                          r_hi;
    logic [7:0]                          r_lo;
    logic [7:0]                          r_first;
    logic [wrtcf_pkg::ModW-1:0]          r_span;
    logic [wrtcf_pkg::FrameLen-1:0][7:0] r_frame;
    logic [wrtcf_pkg::IdxW-1:0]          r_idx;
    logic                                r_out_valid;
    wrtcf_pkg::t_out_item                r_out_item;

    logic                                w_cfg_wr;
    logic                                w_accept;
    logic                                w_mod_start;
    logic [wrtcf_pkg::ModW-1:0]          w_mod_div;
    logic                                w_mod_done;
    logic [wrtcf_pkg::ModW-1:0]          w_mod_rem;
    logic                                w_pick_a;
    logic [wrtcf_pkg::ModW-1:0]          w_span_a;
    logic [wrtcf_pkg::ModW-1:0]          w_span_b;
    logic [wrtcf_pkg::LfsrW-1:0]         w_seeded;
    logic [15:0]                         w_total;
    logic [15:0]                         w_chk;
    logic                                w_load;

    assign pready      = 1'b1;
    assign w_cfg_wr    = psel && penable && pwrite;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_mod_start = (r_state == S_PICK_GO) || (r_state == S_FILE_GO);
    assign w_mod_div   = (r_state == S_PICK_GO) ? wrtcf_pkg::PickMod : r_span;
    assign w_pick_a    = w_mod_rem < {2'b00, r_weight_a};
    // reversed range counts as a single track
    assign w_span_a    = (r_last_a >= r_first_a) ?
                         ({1'b0, r_last_a} - {1'b0, r_first_a} + 9'd1) : 9'd1;
    assign w_span_b    = (r_last_b >= r_first_b) ?
                         ({1'b0, r_last_b} - {1'b0, r_first_b} + 9'd1) : 9'd1;
    assign w_seeded    = r_seed_done ? r_lfsr : (r_lfsr ^ {8'h00, i_in_item.entropy});
    assign w_total     = 16'(wrtcf_pkg::FrameVer) + 16'(wrtcf_pkg::FrameLenB)
                         + 16'(r_cmd) + 16'(r_hi) + 16'(r_lo);
    assign w_chk       = 16'h0000 - w_total;
    assign w_load      = !r_out_valid || i_out_ready;

    wrtcf_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_lfsr),
        .i_divisor  (w_mod_div),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    always_comb begin
        unique case (paddr[4:2])
            wrtcf_pkg::RegFolderA: prdata = {24'h0, r_folder_a};
            wrtcf_pkg::RegFirstA:  prdata = {24'h0, r_first_a};
            wrtcf_pkg::RegLastA:   prdata = {24'h0, r_last_a};
            wrtcf_pkg::RegFolderB: prdata = {24'h0, r_folder_b};
            wrtcf_pkg::RegFirstB:  prdata = {24'h0, r_first_b};
            wrtcf_pkg::RegLastB:   prdata = {24'h0, r_last_b};
            wrtcf_pkg::RegWeightA: prdata = {25'h0, r_weight_a};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_folder_a  <= 8'd1;
            r_first_a   <= 8'd1;
            r_last_a    <= 8'd27;
            r_folder_b  <= 8'd2;
            r_first_b   <= 8'd1;
            r_last_b    <= 8'd43;
            r_weight_a  <= 7'd90;
            r_lfsr      <= wrtcf_pkg::LfsrReset;
            r_seed_done <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (w_cfg_wr) begin
                unique case (paddr[4:2])
                    wrtcf_pkg::RegFolderA: r_folder_a <= pwdata[7:0];
                    wrtcf_pkg::RegFirstA:  r_first_a  <= pwdata[7:0];
                    wrtcf_pkg::RegLastA:   r_last_a   <= pwdata[7:0];
                    wrtcf_pkg::RegFolderB: r_folder_b <= pwdata[7:0];
                    wrtcf_pkg::RegFirstB:  r_first_b  <= pwdata[7:0];
                    wrtcf_pkg::RegLastB:   r_last_b   <= pwdata[7:0];
                    wrtcf_pkg::RegWeightA: r_weight_a <= pwdata[6:0];
                    default: ;
                endcase
            end

            // while sending, the send arm below owns the output register
            if (r_out_valid && i_out_ready && r_state != S_SEND) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in_item.kind) begin
                            r_cmd       <= wrtcf_pkg::PlayCmd;
                            r_lfsr      <= wrtcf_pkg::lfsr_step(w_seeded);
                            r_seed_done <= 1'b1;
                            r_state     <= S_PICK_GO;
                        end else begin
                            r_cmd   <= i_in_item.command;
                            r_hi    <= i_in_item.param_high;
                            r_lo    <= i_in_item.param_low;
                            r_state <= S_SUM;
                        end
                    end
                end
                S_PICK_GO: begin
                    r_state <= S_PICK_WAIT;
                end
                S_PICK_WAIT: begin
                    if (w_mod_done) begin
                        if (w_pick_a) begin
                            r_hi    <= r_folder_a;
                            r_first <= r_first_a;
                            r_span  <= w_span_a;
                        end else begin
                            r_hi    <= r_folder_b;
                            r_first <= r_first_b;
                            r_span  <= w_span_b;
                        end
                        r_lfsr  <= wrtcf_pkg::lfsr_step(r_lfsr);
                        r_state <= S_FILE_GO;
                    end
                end
                S_FILE_GO: begin
                    r_state <= S_FILE_WAIT;
                end
                S_FILE_WAIT: begin
                    if (w_mod_done) begin
                        r_lo    <= r_first + w_mod_rem[7:0];
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_frame <= {wrtcf_pkg::FrameStart, wrtcf_pkg::FrameVer,
                                wrtcf_pkg::FrameLenB, r_cmd, wrtcf_pkg::FrameAck,
                                r_hi, r_lo, w_chk[15:8], w_chk[7:0],
                                wrtcf_pkg::FrameEnd};
                    r_idx   <= '0;
                    r_state <= S_SEND;
                end
                S_SEND: begin
                    // advance one byte whenever the output register is free
                    if (w_load) begin
                        r_out_valid           <= 1'b1;
                        r_out_item.frame_byte <= r_frame[wrtcf_pkg::FrameLen-1];
                        r_out_item.last_byte  <=
                            (r_idx == wrtcf_pkg::IdxW'(wrtcf_pkg::FrameLen - 1));
                        r_frame <= {r_frame[wrtcf_pkg::FrameLen-2:0], 8'h00};
                        r_idx   <= r_idx + 1'b1;
                        if (r_idx == wrtcf_pkg::IdxW'(wrtcf_pkg::FrameLen - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_seed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_seed_done))
        else $error("seed flag cleared outside reset");

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != '0)
        else $error("LFSR reached the all-zero lock-up state");

    a_mod_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == S_PICK_WAIT || r_state == S_FILE_WAIT))
        else $error("remainder finished while not awaited");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND && w_load
         && r_idx == wrtcf_pkg::IdxW'(wrtcf_pkg::FrameLen - 1))
        |=> (o_out_valid && o_out_item.last_byte && r_state == S_IDLE))
        else $error("tenth byte not flagged as last");

endmodule
